// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen at a clock edge
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== hw/rtl/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and character class decode for the syntax checker.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

  localparam int unsigned DEPTH_LIMIT = 255;
  localparam int unsigned DEPTH_W     = $clog2(DEPTH_LIMIT + 1);
  localparam int unsigned CHAR_W      = 8;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  typedef struct packed {
    char_t  prev_char;
    logic   at_start;
    depth_t depth;
    logic   err;
  } esc_state_t;

  localparam esc_state_t STATE_RESET = '{
    prev_char: '0,
    at_start:  1'b1,
    depth:     '0,
    err:       1'b0
  };

  localparam char_t CH_OPEN  = char_t'("(");
  localparam char_t CH_CLOSE = char_t'(")");

  function automatic logic is_digit(input char_t c);
    return (c >= char_t'("0")) && (c <= char_t'("9"));
  endfunction

  function automatic logic is_first_bad(input char_t c);
    return c inside {".", "*", "/", "m", "^"};
  endfunction

  function automatic logic is_final_bad(input char_t c);
    return c inside {".", "*", "/", "m", "^", "+", "-"};
  endfunction

  function automatic logic is_opish_left(input char_t c);
    return c inside {"+", "-", "/", "*", "m", "e", "^", "("};
  endfunction

  function automatic logic is_opish_right(input char_t c);
    return c inside {"*", "/", "^", "e", ".", "m", ")"};
  endfunction

  function automatic logic is_after_dot(input char_t c);
    return c inside {"+", "-", "/", "*", "^", "(", ")", "m", ".", "x", "s", "q",
                     "c", "t", "#", "$", "!", "n", "g"};
  endfunction

  function automatic logic is_after_close(input char_t c);
    return c inside {".", "(", "s", "t", "c", "#", "$", "!", "n", "g", "q", "x"};
  endfunction

  function automatic logic is_after_x(input char_t c);
    return c inside {"(", ".", "e", "s", "c", "t", "q", "#", "$", "!", "n", "g",
                     "x"};
  endfunction

  function automatic logic is_after_e(input char_t c);
    return c inside {"*", "/", "^", "(", ".", "e", "s", "c", "t", "q", "#", "$",
                     "!", "n", "g", "x", "m"};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/esc_check.sv =====
// ----------------------------------------------------------------------------
// esc_check
// Pair rules, first/final checks and bracket depth update for one character.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_check (
  input  esc_pkg::esc_state_t cur,
  input  esc_pkg::char_t      char_code,
  input  logic                last_char,
  output esc_pkg::esc_state_t nxt,
  output logic                result_err
);

  esc_pkg::char_t a;
  logic           pair_bad;
  logic           order_err;
  logic           depth_err;
  esc_pkg::depth_t depth_upd;

  assign a = cur.prev_char;

  always_comb begin
    pair_bad = 1'b0;
    if (esc_pkg::is_opish_left(a) && esc_pkg::is_opish_right(char_code)) pair_bad = 1'b1;
    if ((a == esc_pkg::char_t'(".")) && esc_pkg::is_after_dot(char_code)) pair_bad = 1'b1;
    if (esc_pkg::is_digit(a) &&
        ((char_code == esc_pkg::CH_OPEN) || (char_code == esc_pkg::char_t'("x"))))
      pair_bad = 1'b1;
    if ((a == esc_pkg::CH_CLOSE) &&
        (esc_pkg::is_digit(char_code) || esc_pkg::is_after_close(char_code)))
      pair_bad = 1'b1;
    if ((a == esc_pkg::char_t'("x")) &&
        (esc_pkg::is_digit(char_code) || esc_pkg::is_after_x(char_code)))
      pair_bad = 1'b1;
    if ((a == esc_pkg::char_t'("e")) && esc_pkg::is_after_e(char_code)) pair_bad = 1'b1;
  end

  assign order_err = cur.at_start ? esc_pkg::is_first_bad(char_code) : pair_bad;

  // open saturates at the limit, close saturates at zero; both flag
  always_comb begin
    depth_err = 1'b0;
    depth_upd = cur.depth;
    if (char_code == esc_pkg::CH_OPEN) begin
      if (cur.depth >= esc_pkg::depth_t'(esc_pkg::DEPTH_LIMIT)) depth_err = 1'b1;
      else depth_upd = cur.depth + esc_pkg::depth_t'(1);
    end else if (char_code == esc_pkg::CH_CLOSE) begin
      if (cur.depth == '0) depth_err = 1'b1;
      else depth_upd = cur.depth - esc_pkg::depth_t'(1);
    end
  end

  always_comb begin
    nxt.prev_char = char_code;
    nxt.at_start  = 1'b0;
    nxt.depth     = depth_upd;
    nxt.err       = cur.err | order_err | depth_err;
  end

  assign result_err = nxt.err | (last_char & esc_pkg::is_final_bad(char_code)) |
                      (depth_upd != '0);

endmodule

`default_nettype wire

// ===== hw/rtl/expression_syntax_checker_top.sv =====
// ----------------------------------------------------------------------------
// expression_syntax_checker_top
// Streaming syntax check of calculator expressions, one character per request.
// ----------------------------------------------------------------------------
//  channel | ports                               | direction | flow
//  --------+-------------------------------------+-----------+-----------------
//  in      | in_valid in_stall in_char_code      | in        | valid / stall
//          | in_last_char                        |           |
//  out     | out_valid out_stall out_syntax_error| out       | valid / stall
//
//  One character per cycle unless a final character waits on a stalled output:
//  input register, check logic, result register (loaded by a final character).
//  Only a request with last_char set waits on the result register, so a
//  stalled output holds up the input only behind a final character.
//  Synchronous active-low reset returns the checker to the start state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module expression_syntax_checker_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  esc_pkg::char_t       in_char_code,
  input  logic                 in_last_char,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_syntax_error
);

  logic                s1_valid_r;
  esc_pkg::char_t      s1_char_r;
  logic                s1_last_r;
  esc_pkg::esc_state_t state_r;
  esc_pkg::esc_state_t state_nxt;
  logic                res_err;
  logic                out_valid_r;
  logic                out_err_r;
  logic                out_free;
  logic                s1_fire;
  logic                in_fire;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r <= in_char_code;
      s1_last_r <= in_last_char;
    end
  end

  esc_check u_check (
    .cur        (state_r),
    .char_code  (s1_char_r),
    .last_char  (s1_last_r),
    .nxt        (state_nxt),
    .result_err (res_err)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= esc_pkg::STATE_RESET;
    end else if (s1_fire) begin
      state_r <= s1_last_r ? esc_pkg::STATE_RESET : state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_err_r <= res_err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_syntax_error = out_err_r;

  `ASSERT_CLK(a_end_resets_state,
              s1_fire && s1_last_r |=> state_r == esc_pkg::STATE_RESET,
              "state not cleared after final character")
  `ASSERT_CLK(a_result_from_last,
              $rose(out_valid_r) |-> $past(s1_fire && s1_last_r),
              "result without a final character")
  `ASSERT_NEVER(a_depth_over,
                state_r.depth > esc_pkg::depth_t'(esc_pkg::DEPTH_LIMIT),
                "bracket depth past limit")
  `ASSERT_NEVER(a_lost_result,
                s1_fire && s1_last_r && out_valid_r && out_stall,
                "result register overwritten")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for expression_syntax_checker_top. Expressions are fed
// one character per request; each verdict on a final character is compared
// with a table entry or a cycle-free predictor of bracket, pair, start, end rules.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_LIMIT    = 400000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned RANDOM_VERDICTS = 48;

  localparam logic [7:0] OPEN_BR  = esc_pkg::CH_OPEN;
  localparam logic [7:0] CLOSE_BR = esc_pkg::CH_CLOSE;

  localparam string LEAD_BAD    = ".*/m^";
  localparam string TAIL_BAD    = ".*/m^+-";
  localparam string OP_LEFT     = "+-/*me^(";
  localparam string OP_RIGHT    = "*/^e.m)";
  localparam string DOT_NEXT    = "+-/*^()m.xsqct#$!ng";
  localparam string CLOSE_NEXT  = ".(stc#$!ngqx";
  localparam string VAR_NEXT    = "(.esctq#$!ngx";
  localparam string EXP_NEXT    = "*/^(.esctq#$!ngxm";
  localparam string FUNC_CHARS  = "sctqng#$!";
  localparam string OP_CHARS    = "+-*/^m";
  localparam string ODD_CHARS   = "().*/m^+-xe0123456789sctqng#$!";

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       typed;
    logic       rej;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
    '{".",   1'b1, 1'b1, 1'b1},  // bad lead and tail on one char
    '{"7",   1'b1, 1'b1, 1'b0},
    '{8'h00, 1'b1, 1'b1, 1'b0},  // NUL is an ordinary char
    '{")",   1'b1, 1'b1, 1'b1},  // close at depth zero
    '{"(",   1'b0, 1'b0, 1'b0},
    '{")",   1'b1, 1'b1, 1'b1},  // empty brackets
    '{"(",   1'b0, 1'b0, 1'b0},
    '{"3",   1'b0, 1'b0, 1'b0},
    '{")",   1'b1, 1'b1, 1'b0},
    '{"2",   1'b0, 1'b0, 1'b0},
    '{"-",   1'b1, 1'b1, 1'b1},  // dangling operator
    '{"x",   1'b0, 1'b0, 1'b0},
    '{"4",   1'b1, 1'b1, 1'b1},
    '{"e",   1'b0, 1'b0, 1'b0},
    '{"m",   1'b1, 1'b1, 1'b1},
    '{")",   1'b0, 1'b0, 1'b0},  // error stays set to the end
    '{"(",   1'b0, 1'b0, 1'b0},
    '{"1",   1'b0, 1'b0, 1'b0},
    '{")",   1'b1, 1'b1, 1'b1},
    '{"q",   1'b0, 1'b0, 1'b0},
    '{"(",   1'b0, 1'b0, 1'b0},
    '{"x",   1'b0, 1'b0, 1'b0},
    '{"*",   1'b0, 1'b0, 1'b0},
    '{"2",   1'b0, 1'b0, 1'b0},
    '{")",   1'b1, 1'b0, 1'b0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_code = 8'h00;
  logic       in_last_char = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_syntax_error;

  // predictor state
  logic [7:0] last_seen;
  bit         fresh;
  int         nest_level;
  bit         err_flag;

  logic       verdict_q[$];
  logic [7:0] formula_q[$];
  int         mismatch_cnt;
  int         verdicts_seen;
  int         burst_left;
  bit         gaps_on;
  bit         hold_req;

  expression_syntax_checker_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_syntax_error (out_syntax_error)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit in_class(input logic [7:0] c, input string set);
    if (c == 8'h00) return 1'b0;
    for (int k = 0; k < set.len(); k++) begin
      if (set[k] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit pair_breaks(input logic [7:0] a, input logic [7:0] b);
    if (in_class(a, OP_LEFT) && in_class(b, OP_RIGHT)) return 1'b1;
    if (a == "." && in_class(b, DOT_NEXT)) return 1'b1;
    if (is_num(a) && (b == OPEN_BR || b == "x")) return 1'b1;
    if (a == CLOSE_BR && (is_num(b) || in_class(b, CLOSE_NEXT))) return 1'b1;
    if (a == "x" && (is_num(b) || in_class(b, VAR_NEXT))) return 1'b1;
    if (a == "e" && in_class(b, EXP_NEXT)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void clear_checker();
    last_seen  = 8'h00;
    fresh      = 1'b1;
    nest_level = 0;
    err_flag   = 1'b0;
  endfunction

  // advance the predictor by one accepted character; queue a verdict on the last
  function automatic void judge_char(input logic [7:0] c, input logic last,
                                     input logic typed, input logic rej);
    bit bad;
    bad = err_flag;
    if (fresh) begin
      if (in_class(c, LEAD_BAD)) bad = 1'b1;
    end else if (pair_breaks(last_seen, c)) begin
      bad = 1'b1;
    end
    if (c == OPEN_BR) begin
      if (nest_level >= int'(esc_pkg::DEPTH_LIMIT)) bad = 1'b1;
      else nest_level++;
    end else if (c == CLOSE_BR) begin
      if (nest_level == 0) bad = 1'b1;
      else nest_level--;
    end
    if (last) begin
      if (in_class(c, TAIL_BAD)) bad = 1'b1;
      if (nest_level != 0) bad = 1'b1;
      verdict_q.push_back(typed ? rej : logic'(bad));
      clear_checker();
    end else begin
      last_seen = c;
      fresh     = 1'b0;
      err_flag  = bad;
    end
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last,
                           input logic typed, input logic rej);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_last_char <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    judge_char(c, last, typed, rej);
  endtask

  task automatic send_formula();
    for (int k = 0; k < formula_q.size(); k++) begin
      send_char(formula_q[k], logic'(k == formula_q.size() - 1), 1'b0, 1'b0);
    end
  endtask

  // sender pauses until every verdict is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
  endtask

  task automatic push_number();
    repeat ($urandom_range(1, 3)) formula_q.push_back(8'("0") + 8'($urandom_range(0, 9)));
    case ($urandom_range(0, 5))
      0: begin
        formula_q.push_back(".");
        repeat ($urandom_range(1, 2)) formula_q.push_back(8'("0") + 8'($urandom_range(0, 9)));
      end
      1: begin
        formula_q.push_back("e");
        if ($urandom_range(0, 1)) formula_q.push_back("-");
        formula_q.push_back(8'("0") + 8'($urandom_range(0, 9)));
      end
      default: ;
    endcase
  endtask

  // well-formed expression with random content
  task automatic compose_formula();
    int  open_n;
    int  lim;
    int  pick;
    bit  want_term;
    formula_q.delete();
    open_n    = 0;
    lim       = $urandom_range(1, 20);
    want_term = 1'b1;
    while (1) begin
      if (want_term) begin
        pick = $urandom_range(0, 10);
        if (pick < 4) begin
          push_number();
          want_term = 1'b0;
        end else if (pick < 5) begin
          formula_q.push_back("x");
          want_term = 1'b0;
        end else if (pick < 7 && open_n < 6) begin
          formula_q.push_back(FUNC_CHARS[$urandom_range(0, FUNC_CHARS.len() - 1)]);
          formula_q.push_back(OPEN_BR);
          open_n++;
        end else if (pick < 9 && open_n < 6) begin
          formula_q.push_back(OPEN_BR);
          open_n++;
        end else if (pick == 10 && formula_q.size() == 0) begin
          formula_q.push_back("-");
        end else begin
          push_number();
          want_term = 1'b0;
        end
      end else begin
        if (formula_q.size() >= lim) break;
        if (open_n > 0 && $urandom_range(0, 2) == 0) begin
          formula_q.push_back(CLOSE_BR);
          open_n--;
        end else begin
          formula_q.push_back(OP_CHARS[$urandom_range(0, OP_CHARS.len() - 1)]);
          want_term = 1'b1;
        end
      end
    end
    repeat (open_n) formula_q.push_back(CLOSE_BR);
  endtask

  function automatic logic [7:0] odd_char();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
    return ODD_CHARS[$urandom_range(0, ODD_CHARS.len() - 1)];
  endfunction

  task automatic random_formula();
    int mode;
    mode = $urandom_range(0, 99);
    if (mode < 70) begin
      compose_formula();
    end else if (mode < 80) begin
      compose_formula();
      formula_q[$urandom_range(0, formula_q.size() - 1)] = odd_char();
    end else if (mode < 88) begin
      compose_formula();
      if (formula_q.size() > 1) formula_q.delete($urandom_range(0, formula_q.size() - 1));
    end else begin
      formula_q.delete();
      repeat ($urandom_range(1, 6)) formula_q.push_back(odd_char());
    end
  endtask

  task automatic deep_nesting(input int opens, input int closes);
    formula_q.delete();
    repeat (opens) formula_q.push_back(OPEN_BR);
    formula_q.push_back("1");
    repeat (closes) formula_q.push_back(CLOSE_BR);
    send_formula();
  endtask

  // result checker
  initial begin
    logic want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual syntax_error=%0b",
                   $realtime, out_syntax_error);
          mismatch_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (out_syntax_error !== want) begin
            $display("%0t: syntax_error mismatch, expected %0b, actual %0b",
                     $realtime, want, out_syntax_error);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode_left;
    int stall_pct;
    mode_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(10, 200);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      mode_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= RUN_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int rnd_items;
    int phase;
    int phase_items;
    int verdict_mark;
    mismatch_cnt  = 0;
    verdicts_seen = 0;
    burst_left    = 0;
    gaps_on       = 1'b1;
    hold_req      = 1'b0;
    clear_checker();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_char(DIR_TAB[r].code, DIR_TAB[r].last, DIR_TAB[r].typed, DIR_TAB[r].rej);
    end
    drain();

    deep_nesting(int'(esc_pkg::DEPTH_LIMIT), int'(esc_pkg::DEPTH_LIMIT));
    // one open too many saturates; closes balance the saturated count
    deep_nesting(int'(esc_pkg::DEPTH_LIMIT) + 1, int'(esc_pkg::DEPTH_LIMIT));
    drain();

    rnd_items    = 0;
    phase        = 0;
    verdict_mark = verdicts_seen;
    while (rnd_items < RANDOM_ITEMS || verdicts_seen - verdict_mark < RANDOM_VERDICTS) begin
      gaps_on = (phase % 4 != 0) && (phase % 4 != 1);
      if (phase == 1) hold_req = 1'b1;
      phase_items = 0;
      while (phase_items < 200) begin
        random_formula();
        send_formula();
        phase_items += formula_q.size();
      end
      rnd_items += phase_items;
      if (phase % 2 == 1) drain();
      phase++;
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && verdict_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
